>>> hdl/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg
// Types, character codes and parser state codes shared by the escape
// stripper modules.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UPPER_O = 8'h4F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CSI_BODY_LO  = 8'h20;
    localparam logic [7:0] CSI_BODY_HI  = 8'h3B;
    localparam logic [7:0] CSI_FINAL_LO = 8'h40;
    localparam logic [7:0] CSI_FINAL_HI = 8'h7E;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam logic [2:0] ST_TEXT    = 3'd0;
    localparam logic [2:0] ST_ESC     = 3'd1;
    localparam logic [2:0] ST_CSI     = 3'd2;
    localparam logic [2:0] ST_SS3     = 3'd3;
    localparam logic [2:0] ST_OSC     = 3'd4;
    localparam logic [2:0] ST_OSC_ESC = 3'd5;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       chunk_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        has_byte;
        logic        chunk_end;
        logic [15:0] kept_count;
    } out_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> hdl/aes_front.sv
// ----------------------------------------------------------------------------
// aes_front
// Escape sequence parser: takes one byte per transfer, tracks the parse
// state and kept count, and writes a result into the queue when one is due.
// ----------------------------------------------------------------------------
module aes_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  aes_pkg::in_item_t      item,
    input  aes_pkg::queue_status_t q_status,
    output logic                   q_wr,
    output aes_pkg::out_item_t     q_wr_item
);
    import aes_pkg::*;

    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    logic [15:0] total_reg;
    logic [15:0] total_next;
    logic [15:0] total_upd;
    logic        accept;
    logic        keep;
    logic [2:0]  parse_next;
    logic [7:0]  b;
    logic        last;

    assign accept = push && !q_status.full;
    assign b      = item.in_byte;
    assign last   = item.chunk_last;

    always_comb
    begin
        keep       = 1'b0;
        parse_next = ST_TEXT;
        unique case (state_reg) inside
            ST_ESC:
            begin
                if (b == CH_LBRACK)
                    parse_next = ST_CSI;
                else if (b == CH_UPPER_O)
                    parse_next = ST_SS3;
                else if (b == CH_RBRACK)
                    parse_next = ST_OSC;
                else
                    parse_next = ST_TEXT;
            end
            ST_CSI:
            begin
                if (b >= CSI_BODY_LO && b <= CSI_BODY_HI)
                    parse_next = ST_CSI;
                else if (b >= CSI_FINAL_LO && b <= CSI_FINAL_HI)
                    parse_next = ST_TEXT;
                else if (b == CH_ESC && !last)
                    parse_next = ST_ESC;
                else
                    keep = 1'b1;
            end
            ST_SS3:
                parse_next = ST_TEXT;
            ST_OSC, ST_OSC_ESC:
            begin
                if (state_reg == ST_OSC_ESC && b == CH_BSLASH)
                    parse_next = ST_TEXT;
                else if (b == CH_BEL)
                    parse_next = ST_TEXT;
                else if (b == CH_ESC)
                    parse_next = ST_OSC_ESC;
                else
                    parse_next = ST_OSC;
            end
            default:
            begin
                if (b == CH_ESC && !last)
                    parse_next = ST_ESC;
                else
                    keep = 1'b1;
            end
        endcase
    end

    assign total_upd = (keep && total_reg != COUNT_MAX) ? total_reg + 16'd1 : total_reg;

    always_comb
    begin
        state_next = state_reg;
        total_next = total_reg;
        if (accept)
        begin
            state_next = last ? ST_TEXT : parse_next;
            total_next = last ? 16'd0 : total_upd;
        end
    end

    assign q_wr                 = accept && (keep || last);
    assign q_wr_item.out_byte   = keep ? b : 8'd0;
    assign q_wr_item.has_byte   = keep;
    assign q_wr_item.chunk_end  = last;
    assign q_wr_item.kept_count = total_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_TEXT;
            total_reg <= 16'd0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
        end
    end

endmodule

>>> hdl/aes_queue.sv
// ----------------------------------------------------------------------------
// aes_queue
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module aes_queue #(
    parameter int DEPTH = aes_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr,
    input  aes_pkg::out_item_t     wr_item,
    input  logic                   rd,
    output aes_pkg::out_item_t     rd_item,
    output aes_pkg::queue_status_t status
);
    import aes_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    out_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr = wr && !status.full;
    assign do_rd = rd && !status.empty;
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hdl/aes_back.sv
// ----------------------------------------------------------------------------
// aes_back
// Output stage: moves results from the queue into the output register and
// presents them until a pop transfer takes them.
// ----------------------------------------------------------------------------
module aes_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  aes_pkg::queue_status_t q_status,
    input  aes_pkg::out_item_t     q_rd_item,
    output logic                   q_rd,
    input  logic                   pop,
    output logic                   empty,
    output aes_pkg::out_item_t     result
);
    import aes_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;
    logic      can_load;

    assign can_load = !valid_reg || pop;
    assign q_rd     = can_load && !q_status.empty;
    assign empty    = !valid_reg;
    assign result   = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (can_load)
            valid_next = !q_status.empty;
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
            data_reg <= q_rd_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

endmodule

>>> hdl/ansi_escape_stripper.sv
// ----------------------------------------------------------------------------
// ansi_escape_stripper
// Removes ANSI escape sequences (CSI, SS3, OSC and plain ESC pairs) from a
// chunked terminal byte stream and reports a saturating kept-byte count.
// ----------------------------------------------------------------------------
// One byte is taken per cycle on push while full is low, with no gaps
// between chunks. A result (a kept byte, or the chunk-end marker with the
// count) passes through the queue and the output register to the result
// ports, and one result can be popped every cycle while empty is low. The
// parser updates its state once per byte taken; a queue of QUEUE_DEPTH
// results and the output register absorb pop-side stalls; full rises when
// the queue is full. Dropped bytes give no result unless they end a chunk.
module ansi_escape_stripper #(
    parameter int QUEUE_DEPTH = aes_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  aes_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output aes_pkg::out_item_t result
);
    import aes_pkg::*;

    queue_status_t q_status;
    logic          q_wr;
    logic          q_rd;
    out_item_t     q_wr_item;
    out_item_t     q_rd_item;

    assign full = q_status.full;

    aes_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .q_status  (q_status),
        .q_wr      (q_wr),
        .q_wr_item (q_wr_item)
    );

    aes_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_item (q_wr_item),
        .rd      (q_rd),
        .rd_item (q_rd_item),
        .status  (q_status)
    );

    aes_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_rd_item (q_rd_item),
        .q_rd      (q_rd),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

>>> hdl/aes_checker.sv
// ----------------------------------------------------------------------------
// aes_checker
// Port-level checks for the escape stripper, bound to the top level.
// ----------------------------------------------------------------------------
module aes_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input aes_pkg::in_item_t  item,
    input logic               empty,
    input logic               pop,
    input aes_pkg::out_item_t result
);
    import aes_pkg::*;

    // a chunk's last byte is always followed by a waiting result
    a_chunk_end_seen: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && item.chunk_last) |-> ##2 !empty)
        else $error("no result after chunk end transfer");

    // results without a kept byte exist only to mark a chunk end
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.has_byte) |-> (result.chunk_end && result.out_byte == 8'd0))
        else $error("result without byte is not a chunk end");

    // count never falls back to zero inside a chunk after a kept byte
    a_count_inside_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && result.has_byte && !result.chunk_end)
        |=> (empty || result.kept_count != 16'd0))
        else $error("kept count reset inside a chunk");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed");

endmodule

bind ansi_escape_stripper aes_checker u_aes_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
